@@ sv/srecord_s1_line_parser_core_assert.svh @@
// Assertion macros used by the S1 line parser checker.
// Needs a clk and an active-low rst_n in the scope that uses them.
`ifndef SRECORD_S1_LINE_PARSER_CORE_ASSERT_SVH
`define SRECORD_S1_LINE_PARSER_CORE_ASSERT_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define SRECS1_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("S1 parser check failed");

// Next-cycle implication, checked on every rising edge out of reset.
`define SRECS1_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("S1 parser check failed");

`endif

@@ sv/srecs1_pkg.sv @@
// Shared types and constants for the S1 record line parser.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package srecs1_pkg;

  // Characters of the record header.
  localparam logic [7:0] CHAR_S   = 8'h53;
  localparam logic [7:0] CHAR_ONE = 8'h31;

  // Decoded nibble value that marks a character outside 0-9 and A-F.
  localparam logic [4:0] HEX_INVALID = 5'd16;

  // Byte actions handed from the front end to the back end.
  localparam logic [2:0] OP_NONE    = 3'd0;
  localparam logic [2:0] OP_COUNT   = 3'd1;
  localparam logic [2:0] OP_ADDR_HI = 3'd2;
  localparam logic [2:0] OP_ADDR_LO = 3'd3;
  localparam logic [2:0] OP_DATA    = 3'd4;
  localparam logic [2:0] OP_CKSUM   = 3'd5;

  // Result kinds.
  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // End-of-record status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_HDR   = 2'd1;
  localparam logic [1:0] ST_BAD_LEN   = 2'd2;
  localparam logic [1:0] ST_BAD_CKSUM = 2'd3;

  // One classified request from the front end.
  typedef struct packed {
    logic [2:0] op;
    logic [7:0] value;
    logic [7:0] offset;
    logic       eol;
    logic       hdr_bad;
    logic       len_bad;
  } s1_op_t;

endpackage

@@ sv/srecord_s1_line_parser_core.sv @@
// Top level of the S1 record line parser: front end, request queue, back end.
// Depends on srecs1_pkg, srecs1_front, srecs1_queue and srecs1_back.
//
//   Channel  | Handshake            | Payload
//   ---------+----------------------+-----------------------------------------
//   input    | push / full          | in_char_code, in_end_of_line
//   result   | empty / pop          | out_kind, out_data_byte, out_byte_offset,
//            |                      | out_load_address, out_data_count, out_status
//
// One character is taken per cycle while the queue is not full. A request is
// written into the queue at the edge that accepts its character; the back end
// takes it from the queue once the result register is empty or being popped.
// full rises only when the request queue is full, that is when results are not
// popped; the front end keeps taking characters while a result waits.
// Reset is synchronous and returns both ends to the start of a line.
`timescale 1ns / 1ps

module srecord_s1_line_parser_core
  import srecs1_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_char_code,
  input  logic        in_end_of_line,
  output logic        empty,
  input  logic        pop,
  output logic        out_kind,
  output logic [7:0]  out_data_byte,
  output logic [7:0]  out_byte_offset,
  output logic [15:0] out_load_address,
  output logic [7:0]  out_data_count,
  output logic [1:0]  out_status
);

  logic   accept;
  logic   q_push, q_take, q_empty, q_full;
  s1_op_t fe_op, be_op;

  assign full   = q_full;
  assign accept = push && !q_full;

  // Character classification.
  srecs1_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .char_code   (in_char_code),
    .end_of_line (in_end_of_line),
    .q_push      (q_push),
    .q_op        (fe_op)
  );

  // Decoupling queue.
  srecs1_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_push),
    .wr_op   (fe_op),
    .rd_en   (q_take),
    .rd_op   (be_op),
    .q_empty (q_empty),
    .q_full  (q_full)
  );

  // Record accumulation and results.
  srecs1_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (!q_empty),
    .q_op             (be_op),
    .q_take           (q_take),
    .pop              (pop),
    .empty            (empty),
    .out_kind         (out_kind),
    .out_data_byte    (out_data_byte),
    .out_byte_offset  (out_byte_offset),
    .out_load_address (out_load_address),
    .out_data_count   (out_data_count),
    .out_status       (out_status)
  );

endmodule

@@ sv/srecs1_front.sv @@
// Front end of the S1 parser: tracks the character position, decodes hex pairs
// and classifies each byte. Depends on srecs1_pkg.
`timescale 1ns / 1ps

module srecs1_front
  import srecs1_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [7:0] char_code,
  input  logic       end_of_line,
  output logic       q_push,
  output s1_op_t     q_op
);

  // Upper-case hex digit value, or the invalid mark.
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] v;
    v = HEX_INVALID;
    if (c inside {[8'h30:8'h39]}) begin
      v = {1'b0, c[3:0]};
    end else if (c inside {[8'h41:8'h46]}) begin
      v = {1'b0, c[3:0] + 4'd9};
    end
    return v;
  endfunction

  logic [9:0] pos_r, pos_nxt, pos_inc;
  logic       hdr_r, hdr_nxt;
  logic [7:0] cnt_r, cnt_nxt;
  logic [3:0] hi_r, hi_nxt;
  logic [4:0] nib;
  logic [7:0] bidx;
  logic [7:0] byte_val;
  s1_op_t     op;

  // Classify the character at the current position.
  always_comb begin
    hdr_nxt   = hdr_r;
    cnt_nxt   = cnt_r;
    hi_nxt    = hi_r;
    nib       = hex_value(char_code);
    // Byte index of a low character; only positions up to 513 use it.
    bidx      = pos_r[8:1] - 8'd1;
    byte_val  = nib[4] ? 8'hFF : {hi_r, nib[3:0]};
    op        = '0;
    op.op     = OP_NONE;
    op.value  = byte_val;
    if (pos_r == 10'd0) begin
      if (char_code != CHAR_S) hdr_nxt = 1'b0;
    end else if (pos_r == 10'd1) begin
      if (char_code != CHAR_ONE) hdr_nxt = 1'b0;
    end else if (pos_r <= {1'b0, cnt_r, 1'b0} + 10'd3) begin
      if (!pos_r[0]) begin
        hi_nxt = nib[4] ? 4'hF : nib[3:0];
      end else if (bidx == 8'd0) begin
        op.op   = OP_COUNT;
        cnt_nxt = byte_val;
      end else if (bidx == cnt_r) begin
        op.op = OP_CKSUM;
      end else if (bidx == 8'd1) begin
        op.op = OP_ADDR_HI;
      end else if (bidx == 8'd2) begin
        op.op = OP_ADDR_LO;
      end else begin
        op.op     = OP_DATA;
        op.offset = bidx - 8'd3;
      end
    end

    // Position saturates so that overlong lines still fail the length test.
    pos_inc = (pos_r == 10'd1023) ? pos_r : pos_r + 10'd1;

    // End-of-line verdicts that need only front-end state.
    op.eol     = end_of_line;
    op.hdr_bad = !hdr_nxt || (pos_inc < 10'd2);
    op.len_bad = (cnt_nxt < 8'd3) || (pos_inc != {1'b0, cnt_nxt, 1'b0} + 10'd4);

    pos_nxt = pos_r;
    if (accept) begin
      pos_nxt = end_of_line ? 10'd0 : pos_inc;
    end
  end

  assign q_push = accept && ((op.op != OP_NONE) || end_of_line);
  assign q_op   = op;

  // Per-line state; cleared after the last character.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      hdr_r <= 1'b1;
      cnt_r <= '0;
      hi_r  <= '0;
    end else begin
      pos_r <= pos_nxt;
      if (accept) begin
        if (end_of_line) begin
          hdr_r <= 1'b1;
          cnt_r <= '0;
          hi_r  <= '0;
        end else begin
          hdr_r <= hdr_nxt;
          cnt_r <= cnt_nxt;
          hi_r  <= hi_nxt;
        end
      end
    end
  end

endmodule

@@ sv/srecs1_queue.sv @@
// Small request queue between the parser front end and back end.
// Depends on srecs1_pkg for the request type.
`timescale 1ns / 1ps

module srecs1_queue
  import srecs1_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   wr_en,
  input  s1_op_t wr_op,
  input  logic   rd_en,
  output s1_op_t rd_op,
  output logic   q_empty,
  output logic   q_full
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  s1_op_t        slots_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] fill_r;

  assign q_empty = (fill_r == CW'(0));
  assign q_full  = (fill_r == CW'(DEPTH));
  assign rd_op   = slots_r[rd_ptr_r];

  // Storage is written only on a push into a free slot.
  always_ff @(posedge clk) begin
    if (wr_en && !q_full) begin
      slots_r[wr_ptr_r] <= wr_op;
    end
  end

  // Pointers wrap at the depth; the fill level tracks occupancy.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (wr_en && !q_full) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
      end
      if (rd_en && !q_empty) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
      end
      if ((wr_en && !q_full) && !(rd_en && !q_empty)) begin
        fill_r <= fill_r + CW'(1);
      end else if (!(wr_en && !q_full) && (rd_en && !q_empty)) begin
        fill_r <= fill_r - CW'(1);
      end
    end
  end

endmodule

@@ sv/srecs1_back.sv @@
// Back end of the S1 parser: applies byte requests to the record state and
// drives the result register. Depends on srecs1_pkg.
`timescale 1ns / 1ps

module srecs1_back
  import srecs1_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  s1_op_t      q_op,
  output logic        q_take,
  input  logic        pop,
  output logic        empty,
  output logic        out_kind,
  output logic [7:0]  out_data_byte,
  output logic [7:0]  out_byte_offset,
  output logic [15:0] out_load_address,
  output logic [7:0]  out_data_count,
  output logic [1:0]  out_status
);

  logic [7:0]  sum_r, sum_upd;
  logic [15:0] addr_r, addr_upd;
  logic [7:0]  ck_r, ck_upd;
  logic [7:0]  cnt_r, cnt_upd;
  logic        emit;
  logic [1:0]  status;
  logic [7:0]  dcount;

  logic        out_v_r;
  logic        kind_r;
  logic [7:0]  byte_r, offset_r, dcount_r;
  logic [15:0] addr_out_r;
  logic [1:0]  status_r;

  // Take a request whenever the result register is free or being drained.
  assign q_take = q_valid && (!out_v_r || pop);

  // Apply the byte to the running record state.
  always_comb begin
    sum_upd  = sum_r;
    addr_upd = addr_r;
    ck_upd   = ck_r;
    cnt_upd  = cnt_r;
    case (q_op.op)
      OP_COUNT: begin
        cnt_upd = q_op.value;
        sum_upd = q_op.value;
      end
      OP_ADDR_HI: begin
        sum_upd  = sum_r + q_op.value;
        addr_upd = {q_op.value, addr_r[7:0]};
      end
      OP_ADDR_LO: begin
        sum_upd  = sum_r + q_op.value;
        addr_upd = {addr_r[15:8], q_op.value};
      end
      OP_DATA: begin
        sum_upd = sum_r + q_op.value;
      end
      OP_CKSUM: begin
        ck_upd = q_op.value;
      end
      default: begin
      end
    endcase
  end

  // Status in priority order, and the reported data count.
  always_comb begin
    if (q_op.hdr_bad) begin
      status = ST_BAD_HDR;
    end else if (q_op.len_bad) begin
      status = ST_BAD_LEN;
    end else if ((sum_upd ^ ck_upd) != 8'hFF) begin
      status = ST_BAD_CKSUM;
    end else begin
      status = ST_OK;
    end
    dcount = (cnt_upd >= 8'd3) ? cnt_upd - 8'd3 : 8'd0;
    emit   = q_op.eol || (q_op.op == OP_DATA);
  end

  // Record state; cleared after each end-of-line request.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r  <= '0;
      addr_r <= '0;
      ck_r   <= '0;
      cnt_r  <= '0;
    end else if (q_take) begin
      if (q_op.eol) begin
        sum_r  <= '0;
        addr_r <= '0;
        ck_r   <= '0;
        cnt_r  <= '0;
      end else begin
        sum_r  <= sum_upd;
        addr_r <= addr_upd;
        ck_r   <= ck_upd;
        cnt_r  <= cnt_upd;
      end
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (q_take && emit) begin
      out_v_r <= 1'b1;
    end else if (pop) begin
      out_v_r <= 1'b0;
    end
  end

  // Result payload; a status result carries zero byte and offset.
  always_ff @(posedge clk) begin
    if (q_take && emit) begin
      kind_r     <= q_op.eol ? KIND_STATUS : KIND_DATA;
      byte_r     <= q_op.eol ? 8'd0 : q_op.value;
      offset_r   <= q_op.eol ? 8'd0 : q_op.offset;
      status_r   <= q_op.eol ? status : ST_OK;
      addr_out_r <= addr_upd;
      dcount_r   <= dcount;
    end
  end

  assign empty            = !out_v_r;
  assign out_kind         = kind_r;
  assign out_data_byte    = byte_r;
  assign out_byte_offset  = offset_r;
  assign out_load_address = addr_out_r;
  assign out_data_count   = dcount_r;
  assign out_status       = status_r;

endmodule

@@ sv/srecs1_checker.sv @@
// Port-level checks for the S1 record line parser, bound to the top level.
// Depends on srecs1_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "srecord_s1_line_parser_core_assert.svh"

module srecs1_checker
  import srecs1_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        empty,
  input logic        pop,
  input logic        out_kind,
  input logic [7:0]  out_data_byte,
  input logic [7:0]  out_byte_offset,
  input logic [15:0] out_load_address,
  input logic [7:0]  out_data_count,
  input logic [1:0]  out_status
);

  // A waiting result that is not popped keeps its kind, byte, address and status.
  `SRECS1_ASSERT_NEXT(a_hold, (!empty && !pop), (!empty && $stable(out_kind) && $stable(out_data_byte) && $stable(out_load_address) && $stable(out_status)))

  // Data results carry an ok status.
  `SRECS1_ASSERT_NOW(a_data_status, (!empty && out_kind == KIND_DATA), (out_status == ST_OK))

  // Status results carry no byte and no offset.
  `SRECS1_ASSERT_NOW(a_status_zero, (!empty && out_kind == KIND_STATUS), (out_data_byte == 8'd0 && out_byte_offset == 8'd0))

  // A data byte lies inside the declared data.
  `SRECS1_ASSERT_NOW(a_offset_range, (!empty && out_kind == KIND_DATA), (out_byte_offset < out_data_count))

endmodule

bind srecord_s1_line_parser_core srecs1_checker u_srecs1_checker (.*);
